### rtl/circular_queue_fifo_core_assert.svh
// Assertion macros shared by the checker.
`ifndef CIRCULAR_QUEUE_FIFO_CORE_ASSERT_SVH
`define CIRCULAR_QUEUE_FIFO_CORE_ASSERT_SVH

// Same-cycle implication.
`define CQF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cqf assertion failed");

// Next-cycle implication.
`define CQF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cqf assertion failed");

`endif

### rtl/cqf_pkg.sv
`default_nettype none
package cqf_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int MAX_SLOTS = 16;
  localparam int DATA_W    = 32;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_DISP = 2'd2,
    CMD_STAT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

### rtl/cqf_adv.sv
`default_nettype none
module cqf_adv #(
  parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  wire logic [$clog2((DEPTH < cqf_pkg::MAX_SLOTS) ? DEPTH : cqf_pkg::MAX_SLOTS)-1:0] x,
  input  wire logic [$clog2(((DEPTH < cqf_pkg::MAX_SLOTS) ? DEPTH : cqf_pkg::MAX_SLOTS)+1)-1:0]
                    used,
  output logic      [$clog2((DEPTH < cqf_pkg::MAX_SLOTS) ? DEPTH : cqf_pkg::MAX_SLOTS)-1:0] y
);
  import cqf_pkg::*;

  localparam int USED  = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
  localparam int PTR_W = $clog2(USED);
  localparam int CNT_W = $clog2(USED + 1);

  logic [CNT_W-1:0] n;

  assign n = CNT_W'(x) + CNT_W'(1);
  assign y = (n >= used) ? '0 : n[PTR_W-1:0];

endmodule
`default_nettype wire

### rtl/cqf_store.sv
`default_nettype none
module cqf_store #(
  parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire cqf_pkg::mem_ctl_t       ctl,
  input  wire logic [$clog2((DEPTH < cqf_pkg::MAX_SLOTS) ? DEPTH : cqf_pkg::MAX_SLOTS)-1:0]
                                       wr_addr,
  input  wire logic [$clog2((DEPTH < cqf_pkg::MAX_SLOTS) ? DEPTH : cqf_pkg::MAX_SLOTS)-1:0]
                                       rd_addr,
  input  wire logic [cqf_pkg::DATA_W-1:0] wr_data,
  output logic      [cqf_pkg::DATA_W-1:0] rd_data
);
  import cqf_pkg::*;

  localparam int USED = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;

  logic [DATA_W-1:0] mem [USED];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### rtl/cqf_ctrl.sv
`default_nettype none
module cqf_ctrl #(
  parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cqf_pkg::CAP_W-1:0]      cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     cmd,
  input  wire logic signed [cqf_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          status,
  output logic signed [cqf_pkg::DATA_W-1:0]   data,
  output logic                                last,
  output logic                                is_empty,
  output logic                                is_full,
  output cqf_pkg::mem_ctl_t                   mem_ctl,
  output logic [$clog2((DEPTH < cqf_pkg::MAX_SLOTS) ? DEPTH : cqf_pkg::MAX_SLOTS)-1:0]
                                              wr_addr,
  output logic [$clog2((DEPTH < cqf_pkg::MAX_SLOTS) ? DEPTH : cqf_pkg::MAX_SLOTS)-1:0]
                                              rd_addr,
  output logic [cqf_pkg::DATA_W-1:0]          wr_data,
  input  wire logic [cqf_pkg::DATA_W-1:0]     rd_data
);
  import cqf_pkg::*;

  localparam int USED  = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
  localparam int PTR_W = $clog2(USED);
  localparam int CNT_W = $clog2(USED + 1);
  localparam logic [CNT_W-1:0] USED_RESET = CNT_W'((CAP_RESET > USED) ? USED : CAP_RESET);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t           state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [PTR_W-1:0] walk, walk_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] used, used_next;
  logic             is_disp, is_disp_next;

  logic [PTR_W-1:0] adv_x, adv_y;
  logic             out_free, in_accept, empty_now, full_now;
  logic             out_load, ld_last;
  status_t          ld_status;
  logic [DATA_W-1:0] ld_data;

  cqf_adv #(.DEPTH(DEPTH)) u_adv (
    .x    (adv_x),
    .used (used),
    .y    (adv_y)
  );

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && out_free && !cfg_wr_en);
  assign in_accept = in_valid && !in_stall;
  assign empty_now = (count == '0);
  assign full_now  = (count == used);
  assign wr_data   = value;

  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    walk_next    = walk;
    count_next   = count;
    used_next    = used;
    is_disp_next = is_disp;
    adv_x        = tail;
    rd_addr      = head;
    wr_addr      = tail;
    mem_ctl      = '0;
    out_load     = 1'b0;
    ld_status    = ST_OK;
    ld_data      = '0;
    ld_last      = 1'b1;
    case (state)
      S_IDLE: begin
        if (cfg_wr_en) begin
          if (cfg_wr_data == '0) begin
            used_next = CNT_W'(1);
          end else if (cfg_wr_data > CAP_W'(USED)) begin
            used_next = CNT_W'(USED);
          end else begin
            used_next = CNT_W'(cfg_wr_data);
          end
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
        end else if (in_accept) begin
          case (cmd_t'(cmd))
            CMD_ENQ: begin
              out_load = 1'b1;
              if (full_now) begin
                ld_status = ST_OVERFLOW;
              end else begin
                if (empty_now) begin
                  head_next = '0;
                  tail_next = '0;
                end else begin
                  tail_next = adv_y;
                end
                wr_addr        = tail_next;
                mem_ctl.wr_en  = 1'b1;
                count_next     = count + CNT_W'(1);
              end
            end
            CMD_DEQ: begin
              if (empty_now) begin
                out_load  = 1'b1;
                ld_status = ST_UNDERFLOW;
              end else begin
                adv_x         = head;
                mem_ctl.rd_en = 1'b1;
                if (count == CNT_W'(1)) begin
                  head_next = '0;
                  tail_next = '0;
                end else begin
                  head_next = adv_y;
                end
                count_next   = count - CNT_W'(1);
                is_disp_next = 1'b0;
                state_next   = S_EMIT;
              end
            end
            CMD_DISP: begin
              if (empty_now) begin
                out_load  = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                mem_ctl.rd_en = 1'b1;
                walk_next     = head;
                is_disp_next  = 1'b1;
                state_next    = S_EMIT;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_EMIT: begin
        adv_x = walk;
        if (out_free) begin
          out_load = 1'b1;
          ld_data  = rd_data;
          ld_last  = !is_disp || (walk == tail);
          if (ld_last) begin
            state_next = S_IDLE;
          end else begin
            walk_next     = adv_y;
            rd_addr       = adv_y;
            mem_ctl.rd_en = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      used      <= USED_RESET;
      is_disp   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      tail    <= tail_next;
      count   <= count_next;
      used    <= used_next;
      is_disp <= is_disp_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk <= walk_next;
    if (out_load) begin
      status   <= ld_status;
      data     <= ld_data;
      last     <= ld_last;
      is_empty <= (count_next == '0);
      is_full  <= (count_next == used_next);
    end
  end

endmodule
`default_nettype wire

### rtl/circular_queue_fifo_core.sv
`default_nettype none
// Ring-buffer queue of signed 32-bit words with a run-time capacity of 1 to
// min(DEPTH, 16) slots. Each request carries a command: enqueue, status, and
// a dequeue or display of an empty queue give one result; dequeue of a
// stored word gives its result through the registered memory read port,
// and display gives one result per stored entry, oldest first, at one per
// cycle while out_stall is low, after a first fetch, paced by the single
// read port and the shared pointer-advance unit. The input stalls until the
// last result of a request is in the output register, while that register
// holds a stalled result, and in a cycle with a capacity write. Writing the
// capacity register empties the queue; do so only while idle.
module circular_queue_fifo_core #(
  parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [cqf_pkg::CAP_W-1:0]         cfg_wr_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [1:0]                        cmd,
  input  wire logic signed [cqf_pkg::DATA_W-1:0] value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             status,
  output logic signed [cqf_pkg::DATA_W-1:0]      data,
  output logic                                   last,
  output logic                                   is_empty,
  output logic                                   is_full
);
  import cqf_pkg::*;

  localparam int USED  = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
  localparam int PTR_W = $clog2(USED);

  mem_ctl_t          mem_ctl;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  cqf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .data        (data),
    .last        (last),
    .is_empty    (is_empty),
    .is_full     (is_full),
    .mem_ctl     (mem_ctl),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .wr_data     (wr_data),
    .rd_data     (rd_data)
  );

  cqf_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule
`default_nettype wire

### rtl/cqf_checker.sv
`default_nettype none
`include "circular_queue_fifo_core_assert.svh"
module cqf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [31:0] data,
  input wire logic        last,
  input wire logic        is_empty,
  input wire logic        is_full
);
  import cqf_pkg::*;

  `CQF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(data) && $stable(status) && $stable(last))
  `CQF_ASSERT_IMPL(a_flags_excl, clk, rst, out_valid, !(is_empty && is_full))
  `CQF_ASSERT_IMPL(a_underflow, clk, rst, out_valid && (status == ST_UNDERFLOW), is_empty && last && (data == '0))
  `CQF_ASSERT_IMPL(a_overflow, clk, rst, out_valid && (status == ST_OVERFLOW), is_full && last && (data == '0))

endmodule

bind circular_queue_fifo_core cqf_checker u_cqf_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .data      (data),
  .last      (last),
  .is_empty  (is_empty),
  .is_full   (is_full)
);
`default_nettype wire

### sim/tb_circular_queue_fifo_core.sv
`default_nettype none
module tb_circular_queue_fifo_core;
  timeunit 1ns;
  timeprecision 1ps;

  import cqf_pkg::*;

  localparam int PRED_PTR_W = $clog2(DEPTH_DEF);

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
    logic                     is_empty;
    logic                     is_full;
  } fifo_result_t;

  typedef struct {
    bit               is_cfg;
    logic [CAP_W-1:0] cap;
    cmd_t             op;
    logic [DATA_W-1:0] word;
    bit               typed;
    fifo_result_t     want;
  } stim_row_t;

  typedef struct {
    logic [CAP_W-1:0] cap;
    int               idle;
    int               stall;
    int               count;
  } phase_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_wr_en;
  logic [CAP_W-1:0]         cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic                     last;
  logic                     is_empty;
  logic                     is_full;

  circular_queue_fifo_core #(
    .DEPTH(DEPTH_DEF)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .data       (data),
    .last       (last),
    .is_empty   (is_empty),
    .is_full    (is_full)
  );

  // queue predictor state
  logic [DATA_W-1:0] ring_mem [DEPTH_DEF];
  int                rd_ptr;
  int                wr_ptr;
  bit                ring_empty;
  logic [CAP_W-1:0]  cap_reg;

  fifo_result_t expected_results[$];
  fifo_result_t step_results[$];
  fifo_result_t no_check;
  stim_row_t    directed_rows[$];
  phase_t       phases[$];

  int idle_pct;
  int stall_pct;
  int hold_starts;
  int hold_seen;
  int hold_left;
  int err_count;
  int result_num;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int active_slots();
    int c;
    c = int'(cap_reg);
    if (c < 1) c = 1;
    if (c > DEPTH_DEF) c = DEPTH_DEF;
    if (c > MAX_SLOTS) c = MAX_SLOTS;
    return c;
  endfunction

  function automatic int next_slot(int i);
    return (i + 1 >= active_slots()) ? 0 : i + 1;
  endfunction

  function automatic bit ring_full();
    return !ring_empty && next_slot(wr_ptr) == rd_ptr;
  endfunction

  function automatic void clear_ring();
    rd_ptr     = 0;
    wr_ptr     = 0;
    ring_empty = 1'b1;
  endfunction

  function automatic void add_result(status_t st, logic [DATA_W-1:0] d, logic lst);
    fifo_result_t r;
    r.status   = st;
    r.data     = d;
    r.last     = lst;
    r.is_empty = ring_empty;
    r.is_full  = ring_full();
    step_results.push_back(r);
  endfunction

  function automatic void apply_request(cmd_t op, logic [DATA_W-1:0] word);
    int               i;
    int               lim;
    bit               fin;
    logic [DATA_W-1:0] w;
    step_results.delete();
    case (op)
      CMD_ENQ: begin
        if (ring_full()) begin
          add_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (ring_empty) begin
            rd_ptr     = 0;
            wr_ptr     = 0;
            ring_empty = 1'b0;
          end else begin
            wr_ptr = next_slot(wr_ptr);
          end
          ring_mem[PRED_PTR_W'(wr_ptr)] = word;
          add_result(ST_OK, '0, 1'b1);
        end
      end
      CMD_DEQ: begin
        if (ring_empty) begin
          add_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          w = ring_mem[PRED_PTR_W'(rd_ptr)];
          if (rd_ptr == wr_ptr) clear_ring();
          else rd_ptr = next_slot(rd_ptr);
          add_result(ST_OK, w, 1'b1);
        end
      end
      CMD_DISP: begin
        if (ring_empty) begin
          add_result(ST_EMPTY, '0, 1'b1);
        end else begin
          i   = rd_ptr;
          lim = active_slots();
          for (int k = 0; k < lim; k++) begin
            fin = (i == wr_ptr) || (k + 1 == lim);
            add_result(ST_OK, ring_mem[PRED_PTR_W'(i)], fin);
            if (fin) break;
            i = next_slot(i);
          end
        end
      end
      default: begin
        add_result(ST_OK, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t req_row(cmd_t op, logic [DATA_W-1:0] w);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cap    = '0;
    r.op     = op;
    r.word   = w;
    r.typed  = 1'b0;
    r.want   = no_check;
    return r;
  endfunction

  function automatic stim_row_t chk_row(cmd_t op, logic [DATA_W-1:0] w, status_t st,
                                        logic [DATA_W-1:0] d, logic e, logic f);
    stim_row_t r;
    r = req_row(op, w);
    r.typed         = 1'b1;
    r.want.status   = st;
    r.want.data     = d;
    r.want.last     = 1'b1;
    r.want.is_empty = e;
    r.want.is_full  = f;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CAP_W-1:0] c);
    stim_row_t r;
    r = req_row(CMD_STAT, '0);
    r.is_cfg = 1'b1;
    r.cap    = c;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t mismatch on %s, result %0d: got %h, want %h",
             $realtime, what, result_num, got, want);
    err_count++;
  endtask

  task automatic send_request(cmd_t op, logic [DATA_W-1:0] word, bit typed,
                              fifo_result_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    value    <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_request(op, word);
    if (typed) begin
      expected_results.push_back(want);
    end else begin
      foreach (step_results[j]) expected_results.push_back(step_results[j]);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= c;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cap_reg = c;
    clear_ring();
  endtask

  task automatic run_random(int n);
    int sent;
    int k;
    sent = 0;
    while (sent < n) begin
      k = $urandom_range(1, active_slots() + 2);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int j = 0; j < k; j++) send_request(CMD_ENQ, rand_word(), 1'b0, no_check);
          sent += k;
        end
        4, 5, 6: begin
          for (int j = 0; j < k; j++) send_request(CMD_DEQ, rand_word(), 1'b0, no_check);
          sent += k;
        end
        7: begin
          send_request(CMD_DISP, rand_word(), 1'b0, no_check);
          sent++;
        end
        8: begin
          send_request(CMD_STAT, rand_word(), 1'b0, no_check);
          sent++;
        end
        default: begin
          send_request(cmd_t'(2'($urandom_range(0, 3))), $urandom, 1'b0, no_check);
          sent++;
        end
      endcase
    end
  endtask

  // receiver stall, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_seen != hold_starts) begin
      hold_seen = hold_starts;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    fifo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      result_num++;
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested result", data, '0);
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
        if (data !== want.data) report_mismatch("data", data, want.data);
        if (last !== want.last)
          report_mismatch("last", DATA_W'(last), DATA_W'(want.last));
        if (is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(is_empty), DATA_W'(want.is_empty));
        if (is_full !== want.is_full)
          report_mismatch("is_full", DATA_W'(is_full), DATA_W'(want.is_full));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    cmd         = CMD_STAT;
    value       = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_starts = 0;
    no_check    = '{2'd0, '0, 1'b0, 1'b0, 1'b0};
    cap_reg     = CAP_RESET;
    clear_ring();

    directed_rows.push_back(chk_row(CMD_STAT, 32'h1234_5678, ST_OK, '0, 1'b1, 1'b0));
    directed_rows.push_back(chk_row(CMD_DEQ, '0, ST_UNDERFLOW, '0, 1'b1, 1'b0));
    directed_rows.push_back(chk_row(CMD_DISP, '0, ST_EMPTY, '0, 1'b1, 1'b0));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'h7fff_ffff, ST_OK, '0, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'h8000_0000, ST_OK, '0, 1'b0, 1'b0));
    directed_rows.push_back(req_row(CMD_DISP, '0));
    directed_rows.push_back(chk_row(CMD_DEQ, '0, ST_OK, 32'h7fff_ffff, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(CMD_DEQ, '0, ST_OK, 32'h8000_0000, 1'b1, 1'b0));
    directed_rows.push_back(cfg_row(5'd2));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'hffff_ffff, ST_OK, '0, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'h0000_0000, ST_OK, '0, 1'b0, 1'b1));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'h0000_0005, ST_OVERFLOW, '0, 1'b0, 1'b1));
    directed_rows.push_back(req_row(CMD_DISP, '0));
    directed_rows.push_back(chk_row(CMD_STAT, '0, ST_OK, '0, 1'b0, 1'b1));
    directed_rows.push_back(chk_row(CMD_DEQ, '0, ST_OK, 32'hffff_ffff, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'h5555_5555, ST_OK, '0, 1'b0, 1'b1));
    directed_rows.push_back(req_row(CMD_DISP, '0));
    directed_rows.push_back(chk_row(CMD_DEQ, '0, ST_OK, 32'h0000_0000, 1'b0, 1'b0));
    directed_rows.push_back(chk_row(CMD_DEQ, '0, ST_OK, 32'h5555_5555, 1'b1, 1'b0));
    directed_rows.push_back(cfg_row(5'd0));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'haaaa_aaaa, ST_OK, '0, 1'b0, 1'b1));
    directed_rows.push_back(chk_row(CMD_ENQ, 32'h0000_0001, ST_OVERFLOW, '0, 1'b0, 1'b1));
    directed_rows.push_back(req_row(CMD_DISP, '0));
    directed_rows.push_back(cfg_row(5'd31));
    directed_rows.push_back(chk_row(CMD_STAT, '0, ST_OK, '0, 1'b1, 1'b0));
    directed_rows.push_back(chk_row(CMD_DEQ, '0, ST_UNDERFLOW, '0, 1'b1, 1'b0));

    phases.push_back('{5'd16, 0, 0, 60});
    phases.push_back('{5'd5, 83, 0, 60});
    phases.push_back('{5'd16, 0, 83, 60});
    phases.push_back('{5'd31, 24, 24, 60});
    phases.push_back('{5'd2, 0, 0, 60});
    phases.push_back('{5'd0, 83, 0, 40});
    phases.push_back('{5'd17, 0, 83, 60});
    phases.push_back('{5'd9, 24, 24, 60});

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        write_capacity(directed_rows[r].cap);
      end else begin
        send_request(directed_rows[r].op, directed_rows[r].word, directed_rows[r].typed,
                     directed_rows[r].want);
      end
    end

    foreach (phases[p]) begin
      write_capacity(phases[p].cap);
      idle_pct  = phases[p].idle;
      stall_pct = phases[p].stall;
      run_random(phases[p].count);
    end

    // hold the output while requests keep coming so the block backs up
    write_capacity(5'd16);
    idle_pct  = 0;
    stall_pct = 0;
    hold_starts++;
    for (int j = 0; j < 20; j++) send_request(CMD_ENQ, rand_word(), 1'b0, no_check);
    for (int j = 0; j < 4; j++) send_request(CMD_DISP, '0, 1'b0, no_check);
    for (int j = 0; j < 10; j++) send_request(CMD_DEQ, '0, 1'b0, no_check);
    send_request(CMD_DISP, '0, 1'b0, no_check);

    drain();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
